// File: hdl/battery_protection_controller_macros.svh
// ---------------------------------------------------------------------------
// battery protection controller assertion macros
// shared concurrent assertion forms used by the protection controller
// ---------------------------------------------------------------------------
`ifndef BATTERY_PROTECTION_CONTROLLER_MACROS_SVH
`define BATTERY_PROTECTION_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPC_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BPC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hdl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg
// shared widths, codes, payload and configuration types of the
// battery protection controller
// ---------------------------------------------------------------------------
package bpc_pkg;

   // field widths
   localparam int CELL_W     = 13;
   localparam int PACK_W     = 14;
   localparam int CUR_W      = 13;
   localparam int TEMP_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;
   localparam int BTN_W      = 3;

   // operating mode
   typedef enum logic [1:0] {
      MODE_LOCK      = 2'd0,
      MODE_CHARGE    = 2'd1,
      MODE_DISCHARGE = 2'd2
   } bpc_mode_type;

   // fault codes in priority order
   typedef enum logic [1:0] {
      FAULT_NONE         = 2'd0,
      FAULT_OVER_TEMP    = 2'd1,
      FAULT_OVER_CURRENT = 2'd2,
      FAULT_CELL         = 2'd3
   } bpc_fault_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_OVER     = 3'd0,
      CSR_CELL_UNDER    = 3'd1,
      CSR_PACK_OVER     = 3'd2,
      CSR_CURRENT_LIMIT = 3'd3,
      CSR_TEMP_LIMIT    = 3'd4
   } bpc_csr_index_type;

   // button bit positions in the sampled level vector
   localparam int BTN_CHG_POS = 0;
   localparam int BTN_DSG_POS = 1;
   localparam int BTN_LCK_POS = 2;

   // reset values
   localparam logic [CELL_W-1:0]        CELL_OVER_RST     = 13'd4200;
   localparam logic [CELL_W-1:0]        CELL_UNDER_RST    = 13'd2600;
   localparam logic [PACK_W-1:0]        PACK_OVER_RST     = 14'd12600;
   localparam logic [CUR_W-1:0]         CURRENT_LIMIT_RST = 13'd2600;
   localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST    = 12'sd450;
   localparam logic [BTN_W-1:0]         BTN_RELEASED      = 3'b111;

   // request transaction
   typedef struct packed {
      logic                     charge_button_level;
      logic                     discharge_button_level;
      logic                     lock_button_level;
      logic                     measure_valid;
      logic [CELL_W-1:0]        cell1_mv;
      logic [CELL_W-1:0]        cell2_mv;
      logic [CELL_W-1:0]        cell3_mv;
      logic [PACK_W-1:0]        pack_mv;
      logic [CUR_W-1:0]         current_ma;
      logic signed [TEMP_W-1:0] temp_a_dc;
      logic signed [TEMP_W-1:0] temp_b_dc;
   } bpc_req_type;

   // response transaction
   typedef struct packed {
      logic       charge_on;
      logic       discharge_on;
      logic [1:0] mode_now;
      logic [1:0] fault_code;
      logic       protection_active;
      logic       any_cell_over;
      logic       any_cell_under;
   } bpc_rsp_type;

   // thresholds handed from the register file to the protection logic
   typedef struct packed {
      logic [CELL_W-1:0]        cell_over_mv;
      logic [CELL_W-1:0]        cell_under_mv;
      logic [PACK_W-1:0]        pack_over_mv;
      logic [CUR_W-1:0]         current_limit_ma;
      logic signed [TEMP_W-1:0] temp_limit_dc;
   } bpc_cfg_type;

   // protection state handed back to the top level
   typedef struct packed {
      logic          charge_on;
      logic          discharge_on;
      bpc_fault_type fault;
      logic          cell_over;
      logic          cell_under;
   } bpc_status_type;

endpackage

// File: hdl/bpc_req_if.sv
// ---------------------------------------------------------------------------
// bpc_req_if
// valid/ready request channel carrying one sample transaction
// ---------------------------------------------------------------------------
interface bpc_req_if import bpc_pkg::*; ();
   logic        valid;
   logic        ready;
   bpc_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/bpc_rsp_if.sv
// ---------------------------------------------------------------------------
// bpc_rsp_if
// valid/ready response channel carrying one protection result transaction
// ---------------------------------------------------------------------------
interface bpc_rsp_if import bpc_pkg::*; ();
   logic        valid;
   logic        ready;
   bpc_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/bpc_csr.sv
// ---------------------------------------------------------------------------
// bpc_csr
// threshold registers, written through the plain write port
// ---------------------------------------------------------------------------
module bpc_csr import bpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  write_en,
   input  logic [CSR_IDX_W-1:0]  index,
   input  logic [CSR_DATA_W-1:0] write_data,
   output bpc_cfg_type           cfg
);

   bpc_cfg_type cfg_ff;
   bpc_cfg_type cfg_in;

   // decode the write, upper data bits dropped per register width
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (bpc_csr_index_type'(index))
            CSR_CELL_OVER:     cfg_in.cell_over_mv     = write_data[CELL_W-1:0];
            CSR_CELL_UNDER:    cfg_in.cell_under_mv    = write_data[CELL_W-1:0];
            CSR_PACK_OVER:     cfg_in.pack_over_mv     = write_data[PACK_W-1:0];
            CSR_CURRENT_LIMIT: cfg_in.current_limit_ma = write_data[CUR_W-1:0];
            CSR_TEMP_LIMIT:    cfg_in.temp_limit_dc    = signed'(write_data[TEMP_W-1:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_over_mv     <= CELL_OVER_RST;
         cfg_ff.cell_under_mv    <= CELL_UNDER_RST;
         cfg_ff.pack_over_mv     <= PACK_OVER_RST;
         cfg_ff.current_limit_ma <= CURRENT_LIMIT_RST;
         cfg_ff.temp_limit_dc    <= TEMP_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/bpc_mode.sv
// ---------------------------------------------------------------------------
// bpc_mode
// button falling-edge detection and mode register
// ---------------------------------------------------------------------------
module bpc_mode import bpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [BTN_W-1:0] buttons,
   output bpc_mode_type     mode_in,
   output bpc_mode_type     mode_ff
);

   logic [BTN_W-1:0] prev_buttons_ff;
   logic [BTN_W-1:0] fell;

   // active-low buttons: a press is a 1 -> 0 transition
   assign fell = prev_buttons_ff & ~buttons;

   // lock beats discharge beats charge
   always_comb begin
      priority if (fell[BTN_LCK_POS])   mode_in = MODE_LOCK;
      else if (fell[BTN_DSG_POS])       mode_in = MODE_DISCHARGE;
      else if (fell[BTN_CHG_POS])       mode_in = MODE_CHARGE;
      else                              mode_in = mode_ff;
   end

   // mode and previous button levels
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_LOCK;
         prev_buttons_ff <= BTN_RELEASED;
      end else if (enable) begin
         mode_ff         <= mode_in;
         prev_buttons_ff <= buttons;
      end
   end

endmodule

// File: hdl/bpc_prot.sv
// ---------------------------------------------------------------------------
// bpc_prot
// threshold compares, fault priority and FET drive state
// ---------------------------------------------------------------------------
module bpc_prot import bpc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  bpc_req_type    sample,
   input  bpc_cfg_type    cfg,
   input  bpc_mode_type   mode,
   output bpc_status_type status
);

   bpc_status_type status_ff;
   bpc_status_type status_in;

   logic                     over;
   logic                     under;
   logic                     temp_trip;
   logic                     current_trip;
   logic                     pack_full;
   logic signed [TEMP_W-1:0] temp_a;
   logic signed [TEMP_W-1:0] temp_b;
   bpc_fault_type            fault_in;

   assign temp_a = sample.temp_a_dc;
   assign temp_b = sample.temp_b_dc;

   // parallel threshold compares
   assign over = (sample.cell1_mv >= cfg.cell_over_mv)
              || (sample.cell2_mv >= cfg.cell_over_mv)
              || (sample.cell3_mv >= cfg.cell_over_mv);
   assign under = (sample.cell1_mv <= cfg.cell_under_mv)
               || (sample.cell2_mv <= cfg.cell_under_mv)
               || (sample.cell3_mv <= cfg.cell_under_mv);
   assign temp_trip    = (temp_a >= cfg.temp_limit_dc) || (temp_b >= cfg.temp_limit_dc);
   assign current_trip = sample.current_ma >= cfg.current_limit_ma;
   assign pack_full    = sample.pack_mv >= cfg.pack_over_mv;

   // fault priority
   always_comb begin
      priority if (temp_trip)    fault_in = FAULT_OVER_TEMP;
      else if (current_trip)     fault_in = FAULT_OVER_CURRENT;
      else if (over && under)    fault_in = FAULT_CELL;
      else                       fault_in = FAULT_NONE;
   end

   // FET drive: any fault forces both off, otherwise the mode decides
   always_comb begin
      status_in.fault        = fault_in;
      status_in.cell_over    = over;
      status_in.cell_under   = under;
      status_in.charge_on    = 1'b0;
      status_in.discharge_on = 1'b0;
      if (fault_in == FAULT_NONE) begin
         unique case (mode)
            MODE_CHARGE:    status_in.charge_on    = !(over || pack_full);
            MODE_DISCHARGE: status_in.discharge_on = !under;
            default: begin
               status_in.charge_on    = 1'b0;
               status_in.discharge_on = 1'b0;
            end
         endcase
      end
   end

   // state holds until the next valid measurement
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff.charge_on    <= 1'b0;
         status_ff.discharge_on <= 1'b0;
         status_ff.fault        <= FAULT_NONE;
         status_ff.cell_over    <= 1'b0;
         status_ff.cell_under   <= 1'b0;
      end else if (enable && sample.measure_valid) begin
         status_ff <= status_in;
      end
   end

   assign status = status_ff;

endmodule

// File: hdl/battery_protection_controller.sv
// ---------------------------------------------------------------------------
// battery_protection_controller
// three-cell battery protection: button mode select, fault checks, FET drive
// ---------------------------------------------------------------------------
// Each request transaction is taken into an input register and evaluated
// from there; the result is held in the response register, which is also the
// protection state. One transaction per clock is sustained while responses
// are taken: a request is accepted whenever the input register is empty or
// moves on, and it moves on whenever the response register is empty or being
// taken. The user must write thresholds through the csr port while no
// transaction is in flight; the block does not enforce it. No clearing pass.
`include "battery_protection_controller_macros.svh"

module battery_protection_controller import bpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bpc_req_if.sink               req_ch,
   bpc_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   bpc_req_type    in_data_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;
   logic           eval_fire;
   logic           req_fire;
   bpc_cfg_type    cfg;
   bpc_mode_type   mode_in;
   bpc_mode_type   mode_ff;
   bpc_status_type status;

   // handshake control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign eval_fire    = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register, payload only
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_ch.payload;
      end
   end

   // threshold registers
   bpc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .write_en   (csr_write_en),
      .index      (csr_index),
      .write_data (csr_write_data),
      .cfg        (cfg)
   );

   // mode select
   bpc_mode u_mode (
      .clock   (clock),
      .reset   (reset),
      .enable  (eval_fire),
      .buttons ({in_data_ff.lock_button_level,
                 in_data_ff.discharge_button_level,
                 in_data_ff.charge_button_level}),
      .mode_in (mode_in),
      .mode_ff (mode_ff)
   );

   // protection evaluation
   bpc_prot u_prot (
      .clock  (clock),
      .reset  (reset),
      .enable (eval_fire),
      .sample (in_data_ff),
      .cfg    (cfg),
      .mode   (mode_in),
      .status (status)
   );

   // response transaction straight from the state registers
   assign rsp_ch.valid                     = rsp_valid_ff;
   assign rsp_ch.payload.charge_on         = status.charge_on;
   assign rsp_ch.payload.discharge_on      = status.discharge_on;
   assign rsp_ch.payload.mode_now          = mode_ff;
   assign rsp_ch.payload.fault_code        = status.fault;
   assign rsp_ch.payload.protection_active = (status.fault != FAULT_NONE);
   assign rsp_ch.payload.any_cell_over     = status.cell_over;
   assign rsp_ch.payload.any_cell_under    = status.cell_under;

   // design checks
   `BPC_ASSERT_IMPLY(a_fet_exclusive, clock, reset, 1'b1,
      !(status.charge_on && status.discharge_on), "both FETs driven on")
   `BPC_ASSERT_IMPLY(a_fault_fets_off, clock, reset, status.fault != FAULT_NONE,
      !status.charge_on && !status.discharge_on, "FET on while a fault is active")
   `BPC_ASSERT_NEXT(a_eval_to_rsp, clock, reset, eval_fire,
      rsp_valid_ff, "evaluated transaction not presented on the response")

endmodule
